### src/fltw_pkg.sv
// shared types and constants of the page table walker
package fltw_pkg;

  localparam int TablePages = 64;
  localparam int IndexBits = 9;
  localparam int PageBits = $clog2(TablePages);
  localparam int SlotBits = PageBits + IndexBits;
  localparam int Depth = TablePages * (1 << IndexBits);
  localparam int CountBits = $clog2(TablePages + 1);
  localparam logic [63:0] DirFlags = 64'd7;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StMissing = 2'd1;
  localparam logic [1:0] StExhausted = 2'd2;

  localparam logic OpMap = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef struct packed {
    logic op;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [11:0] flags;
  } req_t;

  typedef struct packed {
    logic [51:0] result_addr;
    logic [1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_EVAL, ST_DONE
  } walk_state_t;

  function automatic logic [IndexBits-1:0] level_index(logic [47:0] va, logic [1:0] lvl);
    logic [47:0] s;
    begin
      case (lvl)
        2'd0: s = va >> 39;
        2'd1: s = va >> 30;
        2'd2: s = va >> 21;
        default: s = va >> 12;
      endcase
      return s[IndexBits-1:0];
    end
  endfunction

endpackage

### src/fltw_if.sv
// valid/ready channel interface
interface fltw_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/fltw_ram.sv
// generic single-port ram with registered read
module fltw_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### src/fltw_front.sv
// input queue: two-entry fifo of accepted items
module fltw_front (
  input  logic clk,
  input  logic rst_n,
  fltw_if.sink in_ch,
  output fltw_pkg::req_t req,
  output logic req_valid,
  input  logic req_take
);
  fltw_pkg::req_t q_r [2];
  logic [1:0] cnt_r;
  logic rd_r;
  logic push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop = req_take && req_valid;
  assign req_valid = (cnt_r != 2'd0);
  assign req = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
    end else begin
      if (push) q_r[rd_r ^ cnt_r[0]] <= in_ch.data;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### src/fltw_back.sv
// walker: clears the store, walks levels, writes entries, holds the result
module fltw_back (
  input  logic clk,
  input  logic rst_n,
  input  fltw_pkg::req_t req,
  input  logic req_valid,
  output logic req_take,
  fltw_if.source out_ch
);
  fltw_pkg::walk_state_t state_r, state_nxt;
  fltw_pkg::req_t cur_r, cur_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic [fltw_pkg::PageBits-1:0] page_r, page_nxt;
  logic [fltw_pkg::CountBits-1:0] used_r, used_nxt;
  logic [fltw_pkg::SlotBits-1:0] clr_r, clr_nxt;
  fltw_pkg::rsp_t rsp_r, rsp_nxt;
  logic we;
  logic [fltw_pkg::SlotBits-1:0] addr, slot;
  logic [63:0] wdata, rdata;
  logic [51:0] pg;

  fltw_ram #(.Width(64), .Depth(fltw_pkg::Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign slot = {page_r, fltw_pkg::level_index(cur_r.virt_addr, lvl_r)};
  assign pg = rdata[63:12];
  assign out_ch.valid = (state_r == fltw_pkg::ST_DONE);
  assign out_ch.data = rsp_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt = cur_r;
    lvl_nxt = lvl_r;
    page_nxt = page_r;
    used_nxt = used_r;
    clr_nxt = clr_r;
    rsp_nxt = rsp_r;
    req_take = 1'b0;
    we = 1'b0;
    addr = slot;
    wdata = '0;
    case (state_r)
      fltw_pkg::ST_CLEAR: begin
        we = 1'b1;
        addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) state_nxt = fltw_pkg::ST_IDLE;
      end
      fltw_pkg::ST_IDLE: begin
        req_take = 1'b1;
        if (req_valid) begin
          cur_nxt = req;
          lvl_nxt = 2'd0;
          page_nxt = '0;
          state_nxt = fltw_pkg::ST_READ;
        end
      end
      fltw_pkg::ST_READ: begin
        if (lvl_r == 2'd3 && cur_r.op == fltw_pkg::OpMap) begin
          we = 1'b1;
          wdata = {12'd0, cur_r.phys_addr} | {52'd0, cur_r.flags};
          rsp_nxt = '{result_addr: '0, status: fltw_pkg::StOk};
          state_nxt = fltw_pkg::ST_DONE;
        end else begin
          state_nxt = fltw_pkg::ST_WAIT;
        end
      end
      fltw_pkg::ST_WAIT: state_nxt = fltw_pkg::ST_EVAL;
      fltw_pkg::ST_EVAL: begin
        if (lvl_r == 2'd3) begin
          rsp_nxt = '{result_addr: {pg[39:0], 12'd0}, status: fltw_pkg::StOk};
          state_nxt = fltw_pkg::ST_DONE;
        end else if (rdata[0] && pg < 52'(fltw_pkg::TablePages)) begin
          page_nxt = pg[fltw_pkg::PageBits-1:0];
          lvl_nxt = lvl_r + 2'd1;
          state_nxt = fltw_pkg::ST_READ;
        end else if (cur_r.op == fltw_pkg::OpLookup) begin
          rsp_nxt = '{result_addr: '0, status: fltw_pkg::StMissing};
          state_nxt = fltw_pkg::ST_DONE;
        end else if (used_r >= fltw_pkg::CountBits'(fltw_pkg::TablePages)) begin
          rsp_nxt = '{result_addr: '0, status: fltw_pkg::StExhausted};
          state_nxt = fltw_pkg::ST_DONE;
        end else begin
          we = 1'b1;
          wdata = (64'(used_r) << 12) | fltw_pkg::DirFlags;
          page_nxt = used_r[fltw_pkg::PageBits-1:0];
          used_nxt = used_r + 1'b1;
          lvl_nxt = lvl_r + 2'd1;
          state_nxt = fltw_pkg::ST_READ;
        end
      end
      fltw_pkg::ST_DONE: begin
        if (out_ch.ready) state_nxt = fltw_pkg::ST_IDLE;
      end
      default: state_nxt = fltw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fltw_pkg::ST_CLEAR;
      used_r <= fltw_pkg::CountBits'(1);
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      clr_r <= clr_nxt;
    end
    cur_r <= cur_nxt;
    lvl_r <= lvl_nxt;
    page_r <= page_nxt;
    rsp_r <= rsp_nxt;
  end
endmodule

### src/four_level_page_table_walker.sv
// top level of the four-level page table walker
//  channel | direction | payload
//  in_     | sink      | op, virt_addr, phys_addr, flags
//  out_    | source    | result_addr, status
// after reset a clearing pass zeroes all 32768 entries of the table store; the queue takes two items
// an item walks each level through the single ram port in read, wait and eval states;
// a map writes its leaf entry in the read state of the last level, a walk may stop early,
// the item is taken in idle, and the result is presented in done until it is accepted
// a two-item input queue keeps accepting, until it is full, while the walker works or its result stalls
module four_level_page_table_walker (
  input  logic clk,
  input  logic rst_n,
  fltw_if.sink in_ch,
  fltw_if.source out_ch
);
  fltw_pkg::req_t req;
  logic req_valid, req_take;

  fltw_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .req(req), .req_valid(req_valid), .req_take(req_take)
  );

  fltw_back u_back (
    .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
    .req_take(req_take), .out_ch(out_ch)
  );

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.status != 2'd3) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.status != fltw_pkg::StOk |-> out_ch.data.result_addr == '0)
    else $error("error result carries an address");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped while stalled");
endmodule
